// ===== rtl/dlz_pkg.sv =====
package dlz_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = RING_AW + 1;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned LEFT_W     = 4;
  localparam int unsigned CFG_AW     = 3;

  localparam logic [RING_AW-1:0] WP_INIT   = RING_AW'(12'hFEE);
  localparam logic [7:0]         FILL_BYTE = 8'h20;
  localparam logic [LEFT_W-1:0]  FLAGS_PER_GROUP = LEFT_W'(8);

  // register select bit of paddr (registers on a 4-byte stride)
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic REG_BYPASS = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef logic [7:0] data8_t;

endpackage

// ===== rtl/dlz_in_if.sv =====
interface dlz_in_if import dlz_pkg::*;;
  logic   valid;
  logic   ready;
  data8_t packed_byte;
  logic   blob_last;

  modport source (output valid, output packed_byte, output blob_last, input ready);
  modport sink   (input valid, input packed_byte, input blob_last, output ready);
endinterface

// ===== rtl/dlz_out_if.sv =====
interface dlz_out_if import dlz_pkg::*;;
  logic   valid;
  logic   ready;
  data8_t data_byte;
  logic   run_last;
  logic   limit_reached;

  modport source (output valid, output data_byte, output run_last, output limit_reached,
                  input ready);
  modport sink   (input valid, input data_byte, input run_last, input limit_reached,
                  output ready);
endinterface

// ===== rtl/dlz_ram.sv =====
module dlz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/descramble_lzss_decompress.sv =====
// Flag byte: taken with no output. Literal and bypass: result registered next cycle.
// Back-reference of L bytes: each byte is a ring read, then a ring write and emit; the
//   ring read is registered, and it waits while the output register holds an unaccepted beat.
// A new beat is taken only when the sequencer is idle and the output register is empty.
// Reset (rst_ni low, asynchronous) clears control and config registers, not the data path or
//   the ring: a fill count marks unwritten entries (read as spaces); end of blob clears it.
module descramble_lzss_decompress import dlz_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dlz_in_if.sink            in_i,
  dlz_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               bypass_q;
  logic [31:0]        limit_q;
  logic [7:0]         blob_pos_q, blob_pos_d;
  logic [7:0]         flag_bits_q, flag_bits_d;
  logic [LEFT_W-1:0]  flag_left_q, flag_left_d;
  logic [7:0]         ref_low_q, ref_low_d;
  logic               await_q, await_d;
  logic [31:0]        emitted_q, emitted_d;
  logic               stopped_q, stopped_d;
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [RING_AW-1:0] pos_q, pos_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic               last_q, last_d;
  logic               hit_q, hit_d;

  logic               out_valid_q, out_valid_d;
  data8_t             out_data_q, out_data_d;
  logic               out_run_last_q, out_run_last_d;
  logic               out_lim_q, out_lim_d;

  logic               in_fire;
  logic               cfg_wr;
  data8_t             b;
  data8_t             rd_data;
  logic               ram_we;
  logic               put_req;
  data8_t             put_v;
  logic               put_last;
  logic               do_clear;
  logic               limit_on;
  logic               passed;
  logic [31:0]        emitted_inc;
  logic               hits;
  logic [RING_AW-1:0] pos_off;

  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.packed_byte - blob_pos_q;

  assign limit_on    = (limit_q != '0);
  assign passed      = limit_on && (emitted_q >= limit_q);
  assign emitted_inc = (emitted_q == '1) ? emitted_q : emitted_q + 32'd1;
  assign hits        = limit_on && (emitted_inc >= limit_q);
  assign pos_off     = pos_q - WP_INIT;

  assign out_o.valid         = out_valid_q;
  assign out_o.data_byte     = out_data_q;
  assign out_o.run_last      = out_run_last_q;
  assign out_o.limit_reached = out_lim_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[REG_SEL_BIT] == REG_LIMIT) ? limit_q : {31'd0, bypass_q};

  dlz_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (put_v),
    .raddr_i (pos_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d        = state_q;
    blob_pos_d     = blob_pos_q;
    flag_bits_d    = flag_bits_q;
    flag_left_d    = flag_left_q;
    ref_low_d      = ref_low_q;
    await_d        = await_q;
    emitted_d      = emitted_q;
    stopped_d      = stopped_q;
    wp_d           = wp_q;
    fill_d         = fill_q;
    pos_d          = pos_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    hit_d          = hit_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_data_d     = out_data_q;
    out_run_last_d = out_run_last_q;
    out_lim_d      = out_lim_q;
    ram_we         = 1'b0;
    put_req        = 1'b0;
    put_v          = b;
    put_last       = 1'b1;
    do_clear       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          blob_pos_d = blob_pos_q + 8'd1;
          do_clear   = in_i.blob_last;
          if (bypass_q) begin
            out_valid_d    = 1'b1;
            out_data_d     = b;
            out_run_last_d = 1'b1;
            out_lim_d      = 1'b0;
          end else if (!stopped_q) begin
            if (await_q) begin
              // start the copy; clearing waits until the run is done
              await_d  = 1'b0;
              pos_d    = {b[7:4], ref_low_q};
              cnt_d    = LEN_W'(b[3:0]) + LEN_W'(2);
              last_d   = in_i.blob_last;
              do_clear = 1'b0;
              state_d  = S_RD;
            end else if (flag_left_q == '0) begin
              flag_bits_d = b;
              flag_left_d = FLAGS_PER_GROUP;
            end else begin
              flag_bits_d = flag_bits_q >> 1;
              flag_left_d = flag_left_q - LEFT_W'(1);
              if (flag_bits_q[0]) begin
                put_req = 1'b1;
              end else begin
                ref_low_d = b;
                await_d   = 1'b1;
              end
            end
          end
        end
      end
      S_RD: begin
        if (stopped_q || passed) begin
          stopped_d = 1'b1;
          do_clear  = last_q;
          state_d   = S_IDLE;
        end else if (!out_valid_q || out_o.ready) begin
          // entries beyond the fill count read as the fill byte
          hit_d   = fill_q[RING_AW] || ({1'b0, pos_off} < fill_q);
          state_d = S_WR;
        end
      end
      S_WR: begin
        put_req  = 1'b1;
        put_v    = hit_q ? rd_data : FILL_BYTE;
        put_last = (cnt_q == '0) || hits;
        if (put_last) begin
          do_clear = last_q;
          state_d  = S_IDLE;
        end else begin
          cnt_d   = cnt_q - LEN_W'(1);
          pos_d   = pos_q + RING_AW'(1);
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (put_req && !stopped_q) begin
      if (passed) begin
        stopped_d = 1'b1;
      end else begin
        ram_we         = 1'b1;
        wp_d           = wp_q + RING_AW'(1);
        emitted_d      = emitted_inc;
        fill_d         = fill_q[RING_AW] ? fill_q : fill_q + FILL_W'(1);
        out_valid_d    = 1'b1;
        out_data_d     = put_v;
        out_run_last_d = put_last;
        out_lim_d      = hits;
        if (hits) begin
          stopped_d = 1'b1;
        end
      end
    end

    if (do_clear) begin
      blob_pos_d  = '0;
      flag_bits_d = '0;
      flag_left_d = '0;
      ref_low_d   = '0;
      await_d     = 1'b0;
      emitted_d   = '0;
      stopped_d   = 1'b0;
      wp_d        = WP_INIT;
      fill_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bypass_q    <= 1'b0;
      limit_q     <= '0;
      blob_pos_q  <= '0;
      flag_bits_q <= '0;
      flag_left_q <= '0;
      ref_low_q   <= '0;
      await_q     <= 1'b0;
      emitted_q   <= '0;
      stopped_q   <= 1'b0;
      wp_q        <= WP_INIT;
      fill_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blob_pos_q  <= blob_pos_d;
      flag_bits_q <= flag_bits_d;
      flag_left_q <= flag_left_d;
      ref_low_q   <= ref_low_d;
      await_q     <= await_d;
      emitted_q   <= emitted_d;
      stopped_q   <= stopped_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        if (paddr[REG_SEL_BIT] == REG_LIMIT) begin
          limit_q <= pwdata;
        end else begin
          bypass_q <= pwdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q          <= pos_d;
    cnt_q          <= cnt_d;
    hit_q          <= hit_d;
    out_data_q     <= out_data_d;
    out_run_last_q <= out_run_last_d;
    out_lim_q      <= out_lim_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_flag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_left_q <= FLAGS_PER_GROUP)
    else $error("flag bit count beyond a group");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> !out_valid_q)
    else $error("copy byte would overwrite a waiting beat");

  a_limit_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lim_q) |-> out_run_last_q)
    else $error("limit beat not marked as last of run");

  a_copy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_fire && !bypass_q && !stopped_q && await_q) |=>
      (state_q == S_RD && !in_i.ready))
    else $error("back-reference start did not hold off input");

endmodule
